// File: src/viseme_hold_filter_smoother_core_macros.svh
// Assertion macros for the viseme hold filter and smoother.
// Used by the top level only; empty bodies when SYNTH is defined.
`ifndef VISEME_HOLD_FILTER_SMOOTHER_CORE_MACROS_SVH
`define VISEME_HOLD_FILTER_SMOOTHER_CORE_MACROS_SVH
`ifndef SYNTH
`define VHF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define VHF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VHF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define VHF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/vhfs_pkg.sv
// Shared types and constants for the viseme hold filter and smoother.
// No dependencies.
package vhfs_pkg;
	localparam int NCH = 15;
	localparam int NLANE_GRP = 5;
	localparam int W = 16;
	localparam int MAX_HOLD_DEF = 16;
	localparam int MAX_HISTORY_DEF = 24;
	localparam logic [W-1:0] HALF_LEVEL = 16'd16384;
	localparam int RUN_MAX = 31;
	localparam int CONS_LO = 6;
	localparam int CONS_HI = 14;
	localparam int NUM_W = 32;
	localparam int DEN_W = 10;

	localparam logic [1:0] REG_SMOOTH = 2'd0;
	localparam logic [1:0] REG_LOCK = 2'd1;
	localparam logic [1:0] REG_DEPTH = 2'd2;
	localparam logic [1:0] REG_HOLD = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_DECIDE,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef logic [NCH-1:0][W-1:0] frame_t;

	// Control from the sequencer to the lanes.
	typedef struct packed {
		logic clear;
		logic acc_en;
		logic div_start;
		logic div_step;
		logic use_smooth;
	} lane_ctl_t;
endpackage

// File: src/vhfs_lane.sv
// One smoothing lane: accumulates the weighted history sum for one channel
// and divides it by the weight total bit-serially. Uses vhfs_pkg.
module vhfs_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vhfs_pkg::lane_ctl_t             ctl,
	input  logic [vhfs_pkg::W-1:0]          cur,
	input  logic [vhfs_pkg::W-1:0]          hist,
	input  logic [6:0]                      wt_cur,
	input  logic [6:0]                      wt_hist,
	input  logic [vhfs_pkg::DEN_W-1:0]      den,
	output logic [vhfs_pkg::W-1:0]          result
);
	logic [vhfs_pkg::NUM_W-1:0] num_q;
	logic [vhfs_pkg::NUM_W-1:0] quo_q;
	logic [vhfs_pkg::DEN_W:0]   rem_q;
	logic                       smooth_q;
	logic [vhfs_pkg::DEN_W:0]   rem_sh;
	logic [vhfs_pkg::DEN_W:0]   den_x;

	assign den_x = {1'b0, den};
	assign rem_sh = {rem_q[vhfs_pkg::DEN_W-1:0], quo_q[vhfs_pkg::NUM_W-1]};

	// Restoring division, one quotient bit per cycle; quotient replaces num.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= 1'b0;
		end else if (ctl.clear) begin
			smooth_q <= ctl.use_smooth;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			num_q <= vhfs_pkg::NUM_W'(cur) * vhfs_pkg::NUM_W'(wt_cur);
		end else if (ctl.acc_en) begin
			num_q <= num_q + vhfs_pkg::NUM_W'(hist) * vhfs_pkg::NUM_W'(wt_hist);
		end
		if (ctl.div_start) begin
			quo_q <= num_q;
			rem_q <= '0;
		end else if (ctl.div_step) begin
			if (rem_sh >= den_x) begin
				rem_q <= rem_sh - den_x;
				quo_q <= {quo_q[vhfs_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[vhfs_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign result = smooth_q ? quo_q[vhfs_pkg::W-1:0] : cur;
endmodule

// File: src/vhfs_hold.sv
// Hold filter: run counters, the frame delay line and the zero marks.
// Uses vhfs_pkg.
module vhfs_hold #(
	parameter int MAX_HOLD = vhfs_pkg::MAX_HOLD_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    mark,
	input  logic                    pop,
	input  logic                    flush_clear,
	input  vhfs_pkg::frame_t        w_in,
	input  logic [15:0]             laugh_in,
	input  logic [5:0]              min_hold,
	output logic [$clog2(MAX_HOLD+2)-1:0] fill,
	output vhfs_pkg::frame_t        head,
	output logic [15:0]             head_laugh
);
	localparam int D = MAX_HOLD + 1;
	localparam int FW = $clog2(MAX_HOLD + 2);

	vhfs_pkg::frame_t         dw_q [D];
	logic [15:0]              dl_q [D];
	logic [vhfs_pkg::NCH-1:0] zm_q [D];
	logic [4:0]               run_q [vhfs_pkg::NCH];
	logic [FW-1:0]            fill_q;
	vhfs_pkg::frame_t         w_q;

	assign fill = fill_q;

	always_comb begin
		for (int c = 0; c < vhfs_pkg::NCH; c++) begin
			head[c] = zm_q[0][c] ? '0 : dw_q[0][c];
		end
		head_laugh = dl_q[0];
	end

	// mark uses the counters before this frame; push follows in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int c = 0; c < vhfs_pkg::NCH; c++) run_q[c] <= '0;
			for (int i = 0; i < D; i++) zm_q[i] <= '0;
		end else begin
			if (mark) begin
				w_q <= w_in;
				for (int c = 0; c < vhfs_pkg::NCH; c++) begin
					if (w_in[c] > vhfs_pkg::HALF_LEVEL) begin
						if (run_q[c] != 5'(vhfs_pkg::RUN_MAX)) run_q[c] <= run_q[c] + 5'd1;
					end else begin
						if (run_q[c] != '0 && {1'b0, run_q[c]} < min_hold) begin
							for (int i = 0; i < D; i++) begin
								if (i < 32'(fill_q) &&
								    32'(i) + 32'(run_q[c]) >= 32'(fill_q))
									zm_q[i][c] <= 1'b1;
							end
						end
						run_q[c] <= '0;
					end
				end
			end else if (push) begin
				dw_q[fill_q[FW-1:0] == FW'(D) ? 0 : fill_q] <= w_q;
				dl_q[fill_q] <= laugh_in;
				zm_q[fill_q] <= '0;
				fill_q <= fill_q + FW'(1);
			end else if (pop) begin
				for (int i = 0; i < D - 1; i++) begin
					dw_q[i] <= dw_q[i+1];
					dl_q[i] <= dl_q[i+1];
					zm_q[i] <= zm_q[i+1];
				end
				zm_q[D-1] <= '0;
				fill_q <= fill_q - FW'(1);
			end
			if (flush_clear) begin
				for (int c = 0; c < vhfs_pkg::NCH; c++) run_q[c] <= '0;
			end
		end
	end
endmodule

// File: src/viseme_hold_filter_smoother_core.sv
// Viseme hold filter and smoother. Frames of 15 weights pass a hold filter
// that zeroes short runs above one half, delayed by min_hold frames, and are
// then smoothed by a linearly weighted average of up to history_depth earlier
// hold-filtered frames; channels 6 to 14 skip smoothing while lock is set.
// Fifteen lanes accumulate and divide in parallel. One frame is taken at a
// time; each result takes a history accumulation and a bit-serial division,
// and a clip end releases the whole delay one result after another. Depends
// on vhfs_pkg, vhfs_lane, vhfs_hold and the macros header.
`include "viseme_hold_filter_smoother_core_macros.svh"
module viseme_hold_filter_smoother_core #(
	parameter int MAX_HOLD    = vhfs_pkg::MAX_HOLD_DEF,
	parameter int MAX_HISTORY = vhfs_pkg::MAX_HISTORY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [4:0]   cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// lanes_0_2, lanes_3_5, lanes_6_8, lanes_9_11, lanes_12_14, laughter_in
	input  logic [255:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_0_2, out_3_5, out_6_8, out_9_11, out_12_14, laughter_out
	output logic [255:0] m_axis_tdata,
	output logic         m_axis_tlast
);
	localparam int NCH = vhfs_pkg::NCH;
	localparam int FW = $clog2(MAX_HOLD + 2);
	localparam int HW = $clog2(MAX_HISTORY + 1);
	localparam int HI = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
	localparam int DIV_CYC = vhfs_pkg::NUM_W;

	vhfs_pkg::state_t state_q, state_d;
	logic             smooth_en_q, lock_q;
	logic [6:0]       depth_q;
	logic [5:0]       hold_q;
	logic             end_q;
	logic [15:0]      laugh_q;
	vhfs_pkg::frame_t in_frame;
	logic [6:0]       cnt_q;
	logic [HW-1:0]    hcnt_q;
	logic [6:0]       kk;
	vhfs_pkg::frame_t hist_q [MAX_HISTORY];
	logic [vhfs_pkg::DEN_W-1:0] den_q;
	logic [FW-1:0]    fill;
	vhfs_pkg::frame_t head, res;
	logic [15:0]      head_laugh;
	logic             mark, push, pop, flush_clear;
	vhfs_pkg::lane_ctl_t ctl;
	logic             out_v_q, out_last_q;
	vhfs_pkg::frame_t out_q;
	logic [15:0]      out_laugh_q;
	logic             emit_last;

	for (genvar c = 0; c < NCH; c++) begin : g_in
		assign in_frame[c] = s_axis_tdata[16*c +: 16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_en_q <= 1'b1;
			lock_q <= 1'b1;
			depth_q <= 7'(4 <= MAX_HISTORY ? 4 : MAX_HISTORY);
			hold_q <= 6'(3 <= MAX_HOLD ? 3 : MAX_HOLD);
		end else if (cfg_we) begin
			case (cfg_index)
				vhfs_pkg::REG_SMOOTH: smooth_en_q <= cfg_data[0];
				vhfs_pkg::REG_LOCK:   lock_q <= cfg_data[0];
				vhfs_pkg::REG_DEPTH: begin
					if (cfg_data == '0) depth_q <= 7'd1;
					else if (32'(cfg_data) > MAX_HISTORY) depth_q <= 7'(MAX_HISTORY);
					else depth_q <= 7'(cfg_data);
				end
				vhfs_pkg::REG_HOLD: begin
					if (32'(cfg_data) > MAX_HOLD) hold_q <= 6'(MAX_HOLD);
					else hold_q <= 6'(cfg_data);
				end
				default: ;
			endcase
		end
	end

	vhfs_hold #(.MAX_HOLD(MAX_HOLD)) u_hold (
		.clk, .arst_n, .push, .mark, .pop, .flush_clear,
		.w_in(in_frame), .laugh_in(laugh_q), .min_hold(hold_q),
		.fill, .head, .head_laugh
	);

	assign kk = (7'(hcnt_q) < depth_q) ? 7'(hcnt_q) : depth_q;
	assign emit_last = end_q && fill == FW'(1);

	// cnt_q walks the history entries during accumulation.
	for (genvar c = 0; c < NCH; c++) begin : g_lane
		logic lk;
		logic [vhfs_pkg::W-1:0] hv;
		vhfs_pkg::lane_ctl_t lc;
		assign lk = lock_q && c >= vhfs_pkg::CONS_LO && c <= vhfs_pkg::CONS_HI;
		assign hv = hist_q[cnt_q[HI-1:0]][c];
		always_comb begin
			lc = ctl;
			lc.use_smooth = ctl.use_smooth && !lk;
		end
		vhfs_lane u_lane (
			.clk, .arst_n, .ctl(lc), .cur(head[c]), .hist(hv),
			.wt_cur(depth_q + 7'd1), .wt_hist(depth_q - cnt_q),
			.den(den_q), .result(res[c])
		);
	end

	always_comb begin
		state_d = state_q;
		mark = 1'b0; push = 1'b0; pop = 1'b0; flush_clear = 1'b0;
		ctl = '0;
		ctl.use_smooth = smooth_en_q && kk != '0;
		s_axis_tready = 1'b0;
		case (state_q)
			vhfs_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					mark = 1'b1;
					state_d = vhfs_pkg::ST_MARK;
				end
			end
			vhfs_pkg::ST_MARK: begin
				push = 1'b1;
				state_d = vhfs_pkg::ST_DECIDE;
			end
			vhfs_pkg::ST_DECIDE: begin
				if ((end_q && fill != '0) || (!end_q && 6'(fill) > hold_q)) begin
					ctl.clear = 1'b1;
					state_d = vhfs_pkg::ST_ACC;
				end else begin
					flush_clear = end_q;
					state_d = vhfs_pkg::ST_IDLE;
				end
			end
			vhfs_pkg::ST_ACC: begin
				if (cnt_q < kk) ctl.acc_en = 1'b1;
				else begin
					ctl.div_start = 1'b1;
					state_d = vhfs_pkg::ST_DIV;
				end
			end
			vhfs_pkg::ST_DIV: begin
				// The quotient is held once all bits are in, while the last beat waits.
				if (cnt_q != 7'(DIV_CYC)) ctl.div_step = 1'b1;
				else if (!out_v_q) state_d = vhfs_pkg::ST_OUT;
			end
			vhfs_pkg::ST_OUT: begin
				pop = 1'b1;
				state_d = vhfs_pkg::ST_DECIDE;
			end
			default: state_d = vhfs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vhfs_pkg::ST_IDLE;
			cnt_q <= '0;
			hcnt_q <= '0;
			end_q <= 1'b0;
			out_v_q <= 1'b0;
			den_q <= '0;
		end else begin
			state_q <= state_d;
			if (mark) end_q <= s_axis_tlast;
			if (ctl.clear) begin
				cnt_q <= '0;
				den_q <= vhfs_pkg::DEN_W'(depth_q) + vhfs_pkg::DEN_W'(1);
			end else if (ctl.acc_en) begin
				cnt_q <= cnt_q + 7'd1;
				den_q <= den_q + vhfs_pkg::DEN_W'(depth_q - cnt_q);
			end else if (ctl.div_start) cnt_q <= '0;
			else if (ctl.div_step) cnt_q <= cnt_q + 7'd1;
			if (m_axis_tready) out_v_q <= 1'b0;
			if (pop) begin
				out_v_q <= 1'b1;
				if (emit_last) hcnt_q <= '0;
				else if (7'(hcnt_q) + 7'd1 > depth_q) hcnt_q <= HW'(depth_q);
				else hcnt_q <= hcnt_q + HW'(1);
			end
			if (flush_clear) hcnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mark) laugh_q <= s_axis_tdata[16*NCH +: 16];
		if (pop) begin
			out_q <= res;
			out_laugh_q <= head_laugh;
			out_last_q <= emit_last;
			hist_q[0] <= head;
			for (int i = 1; i < MAX_HISTORY; i++) hist_q[i] <= hist_q[i-1];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast = out_last_q;
	assign m_axis_tdata = {out_laugh_q, out_q};

	`VHF_ASSERT_IMPL(a_out_only_idle_in, clk, arst_n, s_axis_tready, state_q == vhfs_pkg::ST_IDLE, "ready outside idle")
	`VHF_ASSERT_NEXT(a_pop_valid, clk, arst_n, pop, m_axis_tvalid, "result not presented")
	`VHF_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, 32'(fill) <= MAX_HOLD + 1, "delay overfilled")
endmodule
